// ===== hw/rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types, codes and command/status bundles of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int OPCODE_W      = 3;
   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 2;
   localparam int COUNT_W       = 5;

   typedef logic [OPCODE_W-1:0]       opcode_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [STATUS_W-1:0]       status_type;
   typedef logic [COUNT_W-1:0]        count_type;

   localparam opcode_type OP_PUSH_BACK  = 3'd0;
   localparam opcode_type OP_PUSH_FRONT = 3'd1;
   localparam opcode_type OP_POP_BACK   = 3'd2;
   localparam opcode_type OP_POP_FRONT  = 3'd3;
   localparam opcode_type OP_DELETE     = 3'd4;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_EMPTY   = 2'd1;
   localparam status_type ST_FULL    = 2'd2;
   localparam status_type ST_NOMATCH = 2'd3;

   typedef struct packed {
      logic push_back;
      logic push_front;
      logic push_full;
      logic pop_back;
      logic pop_front;
      logic pop_empty;
      logic pop_finish;
      logic nop_finish;
      logic scan_start;
      logic scan_read;
      logic scan_next;
      logic nomatch_finish;
      logic shift_read;
      logic shift_write;
      logic delete_finish;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic match;
      logic at_last;
      logic shift_tail;
   } dp_status_type;

endpackage

// ===== hw/rtl/bdq_req_if.sv =====
// ----------------------------------------------------------------------------
// bdq_req_if
// Request channel: opcode and value with valid/ready.
// ----------------------------------------------------------------------------
interface bdq_req_if;
   import bdq_pkg::*;

   logic       valid;
   logic       ready;
   opcode_type opcode;
   value_type  value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink (input valid, input opcode, input value, output ready);

endinterface

// ===== hw/rtl/bdq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bdq_rsp_if
// Response channel: popped value, status and entry count with valid/ready.
// ----------------------------------------------------------------------------
interface bdq_rsp_if;
   import bdq_pkg::*;

   logic       valid;
   logic       ready;
   value_type  popped_value;
   status_type status;
   count_type  entry_count;

   modport source (output valid, output popped_value, output status, output entry_count,
                   input ready);
   modport sink (input valid, input popped_value, input status, input entry_count,
                 output ready);

endinterface

// ===== hw/rtl/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: decodes transfers, walks deletes, owns the response valid.
// ----------------------------------------------------------------------------
module bdq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  bdq_pkg::opcode_type    req_opcode,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bdq_pkg::dp_status_type status,
   output bdq_pkg::dp_cmd_type    cmd
);
   import bdq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_DONE,
      S_SCAN_READ,
      S_SCAN_CHECK,
      S_SHIFT_READ,
      S_SHIFT_WRITE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      finish;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      finish    = 1'b0;
      req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
      accept    = req_valid && req_ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_PUSH_BACK: begin
                     if (status.full) cmd.push_full = 1'b1;
                     else cmd.push_back = 1'b1;
                     finish = 1'b1;
                  end
                  OP_PUSH_FRONT: begin
                     if (status.full) cmd.push_full = 1'b1;
                     else cmd.push_front = 1'b1;
                     finish = 1'b1;
                  end
                  OP_POP_BACK: begin
                     if (status.empty) begin
                        cmd.pop_empty = 1'b1;
                        finish        = 1'b1;
                     end else begin
                        cmd.pop_back = 1'b1;
                        state_in     = S_POP_DONE;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (status.empty) begin
                        cmd.pop_empty = 1'b1;
                        finish        = 1'b1;
                     end else begin
                        cmd.pop_front = 1'b1;
                        state_in      = S_POP_DONE;
                     end
                  end
                  OP_DELETE: begin
                     if (status.empty) begin
                        cmd.nomatch_finish = 1'b1;
                        finish             = 1'b1;
                     end else begin
                        cmd.scan_start = 1'b1;
                        state_in       = S_SCAN_READ;
                     end
                  end
                  default: begin
                     cmd.nop_finish = 1'b1;
                     finish         = 1'b1;
                  end
               endcase
            end
         end
         S_POP_DONE: begin
            cmd.pop_finish = 1'b1;
            finish         = 1'b1;
            state_in       = S_IDLE;
         end
         S_SCAN_READ: begin
            cmd.scan_read = 1'b1;
            state_in      = S_SCAN_CHECK;
         end
         S_SCAN_CHECK: begin
            if (status.match) begin
               if (status.at_last) begin
                  cmd.delete_finish = 1'b1;
                  finish            = 1'b1;
                  state_in          = S_IDLE;
               end else begin
                  state_in = S_SHIFT_READ;
               end
            end else if (status.at_last) begin
               cmd.nomatch_finish = 1'b1;
               finish             = 1'b1;
               state_in           = S_IDLE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_READ;
            end
         end
         S_SHIFT_READ: begin
            cmd.shift_read = 1'b1;
            state_in       = S_SHIFT_WRITE;
         end
         S_SHIFT_WRITE: begin
            cmd.shift_write = 1'b1;
            if (status.shift_tail) begin
               cmd.delete_finish = 1'b1;
               finish            = 1'b1;
               state_in          = S_IDLE;
            end else begin
               state_in = S_SHIFT_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_valid_in = finish || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_busy_output_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("result pending while an operation is in progress");

   a_pop_gives_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP_DONE) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("pop did not complete with a result");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> rsp_valid_ff)
      else $error("stalled result dropped");
`endif

endmodule

// ===== hw/rtl/bdq_dp.sv =====
// ----------------------------------------------------------------------------
// bdq_dp
// Datapath: ring pointers, entry RAM, delete scan position, result register.
// ----------------------------------------------------------------------------
module bdq_dp #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bdq_pkg::dp_cmd_type    cmd,
   output bdq_pkg::dp_status_type status,
   input  bdq_pkg::value_type     req_value,
   output bdq_pkg::value_type     rsp_popped_value,
   output bdq_pkg::status_type    rsp_status,
   output bdq_pkg::count_type     rsp_entry_count
);
   import bdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   value_type        value_ff, value_in;
   value_type        popped_ff, popped_in;
   status_type       status_ff, status_in;
   count_type        rcount_ff, rcount_in;
   logic             res_load;

   logic [IDX_W-1:0] front_dec, front_inc;
   logic [IDX_W-1:0] rd_pos, wr_pos, rd_slot, wr_slot;
   logic [IDX_W:0]   rd_sum, wr_sum;
   logic [CNT_W:0]   pos_ext, count_ext;
   logic             rd_en, wr_en;
   value_type        wr_data, rd_data;

   always_comb begin
      front_dec = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - 1'b1;
      front_inc = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + 1'b1;

      rd_pos = pos_ff;
      if (cmd.pop_back) rd_pos = IDX_W'(count_ff - 1'b1);
      else if (cmd.pop_front) rd_pos = '0;
      else if (cmd.shift_read) rd_pos = pos_ff + 1'b1;
      rd_sum  = {1'b0, front_ff} + {1'b0, rd_pos};
      rd_slot = (rd_sum >= (IDX_W+1)'(DEPTH)) ? IDX_W'(rd_sum - (IDX_W+1)'(DEPTH))
                                              : rd_sum[IDX_W-1:0];
      rd_en   = cmd.pop_back || cmd.pop_front || cmd.scan_read || cmd.shift_read;

      wr_pos  = cmd.push_back ? IDX_W'(count_ff) : pos_ff;
      wr_sum  = {1'b0, front_ff} + {1'b0, wr_pos};
      wr_slot = (wr_sum >= (IDX_W+1)'(DEPTH)) ? IDX_W'(wr_sum - (IDX_W+1)'(DEPTH))
                                              : wr_sum[IDX_W-1:0];
      if (cmd.push_front) wr_slot = front_dec;
      wr_en   = cmd.push_back || cmd.push_front || cmd.shift_write;
      wr_data = cmd.shift_write ? rd_data : req_value;
   end

   bdq_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_slot),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_slot),
      .rd_data (rd_data)
   );

   always_comb begin
      pos_ext   = (CNT_W+1)'(pos_ff);
      count_ext = {1'b0, count_ff};

      status.full       = (count_ff == CNT_W'(DEPTH));
      status.empty      = (count_ff == '0);
      status.match      = (rd_data == value_ff);
      status.at_last    = (pos_ext + 1'b1 == count_ext);
      status.shift_tail = (pos_ext + 2'd2 == count_ext);

      front_in = front_ff;
      if (cmd.push_front) front_in = front_dec;
      else if (cmd.pop_front) front_in = front_inc;

      count_in = count_ff;
      if (cmd.push_back || cmd.push_front) count_in = count_ff + 1'b1;
      else if (cmd.pop_back || cmd.pop_front || cmd.delete_finish) count_in = count_ff - 1'b1;

      pos_in = pos_ff;
      if (cmd.scan_start) pos_in = '0;
      else if (cmd.scan_next || cmd.shift_write) pos_in = pos_ff + 1'b1;

      value_in = cmd.scan_start ? req_value : value_ff;

      res_load = cmd.push_back || cmd.push_front || cmd.push_full || cmd.pop_empty ||
                 cmd.pop_finish || cmd.nop_finish || cmd.nomatch_finish ||
                 cmd.delete_finish;
      popped_in = cmd.pop_finish ? rd_data : '0;
      status_in = ST_OK;
      if (cmd.push_full) status_in = ST_FULL;
      else if (cmd.pop_empty) status_in = ST_EMPTY;
      else if (cmd.nomatch_finish) status_in = ST_NOMATCH;
      rcount_in = COUNT_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (res_load) begin
         popped_ff <= popped_in;
         status_ff <= status_in;
         rcount_ff <= rcount_in;
      end
   end

   assign rsp_popped_value = popped_ff;
   assign rsp_status       = status_ff;
   assign rsp_entry_count  = rcount_ff;

`ifndef SYNTHESIS
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.push_back || cmd.push_front) |-> !status.full)
      else $error("push written into a full queue");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.pop_back || cmd.pop_front) |-> !status.empty)
      else $error("pop issued on an empty queue");
`endif

endmodule

// ===== hw/rtl/bounded_deque_with_delete.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_delete
// Bounded double-ended queue of signed words with delete-first-match.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries an opcode and a value; rsp_chan returns one result per
//   request: popped value, status and entry count after the operation.
//   Both channels transfer when valid and ready are high at a clock edge.
//   Push, unused opcodes, and a pop or delete on an empty queue finish in
//   the accepting state; a pop passes through S_POP_DONE for the RAM read;
//   a delete alternates S_SCAN_READ and S_SCAN_CHECK per entry up to the
//   match, then S_SHIFT_READ/S_SHIFT_WRITE per entry moved to close the gap.
//   Pushes sustain one transfer per cycle while each result is taken; a
//   pop holds req_chan.ready low for the registered read of the entry RAM;
//   a delete does so while it walks the RAM through its single read port.
//   Results sit in an output register; a push is still taken while a result
//   waits if that result transfers in the same cycle, otherwise the request
//   side stalls until the receiver takes it.
//   Reset (synchronous, active high) empties the queue; entry RAM contents
//   are left as they are and never read before being written.
// ----------------------------------------------------------------------------
module bounded_deque_with_delete #(
   parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
   input logic          clock,
   input logic          reset,
   bdq_req_if.sink      req_chan,
   bdq_rsp_if.source    rsp_chan
);
   import bdq_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   bdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .status     (status),
      .cmd        (cmd)
   );

   bdq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_chan.value),
      .rsp_popped_value (rsp_chan.popped_value),
      .rsp_status       (rsp_chan.status),
      .rsp_entry_count  (rsp_chan.entry_count)
   );

endmodule

// ===== dv/deque_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches the request and result channels of the bounded deque, keeps a
// queue-based copy of the deque contents, predicts every result in order
// and compares each transferred result field by field.
// ----------------------------------------------------------------------------
module deque_checker (
   input  logic clock,
   input  logic reset,
   bdq_req_if   req_mon,
   bdq_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   ok_count,
   output int   empty_count,
   output int   full_count,
   output int   nomatch_count,
   output int   delete_hits
);
   import bdq_pkg::*;

   localparam int CAPACITY = DEPTH_DEFAULT;

   typedef struct packed {
      value_type  popped_value;
      status_type status;
      count_type  entry_count;
   } deque_result_type;

   value_type        deque_contents[$];
   deque_result_type pending_results[$];
   deque_result_type want;
   deque_result_type got;

   function automatic deque_result_type deque_step_result(opcode_type op, value_type val);
      deque_result_type r;
      int               hit;
      r.popped_value = '0;
      r.status       = ST_OK;
      hit            = -1;
      case (op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (deque_contents.size() >= CAPACITY) begin
               r.status = ST_FULL;
            end else if (op == OP_PUSH_BACK) begin
               deque_contents.push_back(val);
            end else begin
               deque_contents.push_front(val);
            end
         end
         OP_POP_BACK, OP_POP_FRONT: begin
            if (deque_contents.size() == 0) begin
               r.status = ST_EMPTY;
            end else if (op == OP_POP_BACK) begin
               r.popped_value = deque_contents.pop_back();
            end else begin
               r.popped_value = deque_contents.pop_front();
            end
         end
         OP_DELETE: begin
            for (int i = 0; i < deque_contents.size() && hit < 0; i++) begin
               if (deque_contents[i] == val) hit = i;
            end
            if (hit < 0) begin
               r.status = ST_NOMATCH;
            end else begin
               deque_contents.delete(hit);
            end
         end
         default: begin
         end
      endcase
      r.entry_count = count_type'(deque_contents.size());
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         deque_contents.delete();
         pending_results.delete();
      end else begin
         // compare first: a result never belongs to a request taken this edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.popped_value = rsp_mon.popped_value;
            got.status       = rsp_mon.status;
            got.entry_count  = rsp_mon.entry_count;
            if (pending_results.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, %s %0d status %0d count %0d",
                        $time, "actual value", got.popped_value, got.status,
                        got.entry_count);
            end else begin
               want = pending_results.pop_front();
               if (got.popped_value !== want.popped_value) begin
                  fail_count++;
                  $display("%0t: popped_value mismatch, expected %0d, actual %0d",
                           $time, want.popped_value, got.popped_value);
               end
               if (got.status !== want.status) begin
                  fail_count++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, got.status);
               end
               if (got.entry_count !== want.entry_count) begin
                  fail_count++;
                  $display("%0t: entry_count mismatch, expected %0d, actual %0d",
                           $time, want.entry_count, got.entry_count);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want = deque_step_result(req_mon.opcode, req_mon.value);
            pending_results.push_back(want);
            case (want.status)
               ST_OK: begin
                  ok_count++;
                  if (req_mon.opcode == OP_DELETE) delete_hits++;
               end
               ST_EMPTY:   empty_count++;
               ST_FULL:    full_count++;
               ST_NOMATCH: nomatch_count++;
               default: begin
               end
            endcase
         end
      end
      pending = pending_results.size();
   end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the bounded deque testbench. Drives a directed opening and then
// phases of random requests (fill, drain, delete-heavy, mixed) in bursts
// with gaps, stalls the result side on shifting patterns with one long
// hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
   import bdq_pkg::*;

   localparam int RANDOM_ITEMS = 1080;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 4000;
   localparam int TAIL_CYCLES  = 80;

   localparam int MIX_FILL   = 0;
   localparam int MIX_DRAIN  = 1;
   localparam int MIX_DELETE = 2;
   localparam int MIX_ANY    = 3;

   localparam opcode_type OP_SPARE_A = 3'd5;
   localparam opcode_type OP_SPARE_B = 3'd6;
   localparam opcode_type OP_SPARE_C = 3'd7;

   localparam value_type VAL_MAX = 32'sh7FFF_FFFF;
   localparam value_type VAL_MIN = 32'sh8000_0000;
   localparam value_type VAL_NEG = -32'sd1;
   localparam value_type VAL_A5  = 32'sh5555_5555;
   localparam value_type VAL_5A  = 32'shAAAA_AAAA;

   logic clock = 1'b0;
   logic reset;
   bit   hold_request = 1'b0;

   int fail_count;
   int pending;
   int ok_count;
   int empty_count;
   int full_count;
   int nomatch_count;
   int delete_hits;

   value_type value_pool[8];

   bdq_req_if req_chan ();
   bdq_rsp_if rsp_chan ();

   bounded_deque_with_delete u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   deque_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending       (pending),
      .ok_count      (ok_count),
      .empty_count   (empty_count),
      .full_count    (full_count),
      .nomatch_count (nomatch_count),
      .delete_hits   (delete_hits)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hold valid high until the transfer
   task automatic send_item(input opcode_type op, input value_type val);
      req_chan.valid  <= 1'b1;
      req_chan.opcode <= op;
      req_chan.value  <= val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic value_type pick_value(int pool_percent);
      if ($urandom_range(0, 99) < pool_percent) return value_pool[$urandom_range(0, 7)];
      return value_type'($urandom);
   endfunction

   function automatic opcode_type pick_opcode(int mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_FILL: begin
            if (roll < 40) return OP_PUSH_BACK;
            if (roll < 75) return OP_PUSH_FRONT;
            if (roll < 85) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            if (roll < 95) return OP_DELETE;
         end
         MIX_DRAIN: begin
            if (roll < 35) return OP_POP_BACK;
            if (roll < 70) return OP_POP_FRONT;
            if (roll < 80) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            if (roll < 95) return OP_DELETE;
         end
         MIX_DELETE: begin
            if (roll < 30) return OP_PUSH_BACK;
            if (roll < 45) return OP_PUSH_FRONT;
            if (roll < 75) return OP_DELETE;
            if (roll < 90) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
         end
         default: begin
            if (roll < 90) return opcode_type'($urandom_range(0, 4));
         end
      endcase
      return opcode_type'($urandom_range(0, 7));
   endfunction

   // result side: shifting stall patterns, plus one long hold-off on request
   initial begin
      int span;
      int style;
      rsp_chan.ready <= 1'b0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            for (span = 0; span < HOLD_CYCLES; span++) begin
               rsp_chan.ready <= 1'b0;
               @(posedge clock);
            end
         end
         style = $urandom_range(0, 3);
         span  = $urandom_range(8, 60);
         repeat (span) begin
            case (style)
               0:       rsp_chan.ready <= 1'b1;
               1:       rsp_chan.ready <= $urandom_range(0, 1);
               2:       rsp_chan.ready <= ($urandom_range(0, 9) != 0);
               default: rsp_chan.ready <= ~rsp_chan.ready;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int        sent;
      int        phase;
      int        mix;
      int        phase_len;
      int        k;
      int        burst;
      int        gap;
      opcode_type op;
      reset           <= 1'b1;
      req_chan.valid  <= 1'b0;
      req_chan.opcode <= OP_PUSH_BACK;
      req_chan.value  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty queue, spare opcodes
      send_item(OP_POP_BACK, VAL_MAX);
      send_item(OP_POP_FRONT, VAL_MIN);
      send_item(OP_DELETE, '0);
      send_item(OP_SPARE_A, VAL_NEG);
      send_item(OP_SPARE_B, VAL_A5);
      send_item(OP_SPARE_C, VAL_5A);
      // extremes at both ends, front push wraps the ring
      send_item(OP_PUSH_BACK, VAL_MAX);
      send_item(OP_PUSH_FRONT, VAL_MIN);
      send_item(OP_PUSH_BACK, '0);
      send_item(OP_PUSH_FRONT, VAL_NEG);
      send_item(OP_PUSH_BACK, VAL_A5);
      send_item(OP_PUSH_BACK, VAL_5A);
      // delete at front, back, middle, and a miss
      send_item(OP_DELETE, VAL_NEG);
      send_item(OP_DELETE, VAL_5A);
      send_item(OP_DELETE, '0);
      send_item(OP_DELETE, 32'sd1);
      // duplicate: only the first from the front goes
      send_item(OP_PUSH_BACK, VAL_MIN);
      send_item(OP_DELETE, VAL_MIN);
      send_item(OP_POP_FRONT, '0);
      send_item(OP_POP_BACK, '0);
      send_item(OP_POP_BACK, '0);
      wait_drained();

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase % 6 == 4) wait_drained();
         for (k = 0; k < 8; k++) begin
            case ($urandom_range(0, 5))
               0:       value_pool[k] = VAL_MAX;
               1:       value_pool[k] = VAL_MIN;
               2:       value_pool[k] = '0;
               3:       value_pool[k] = VAL_NEG;
               default: value_pool[k] = value_type'($urandom);
            endcase
         end
         if (phase == 2) begin
            hold_request = 1'b1;
            mix          = MIX_FILL;
            phase_len    = 120;
         end else begin
            mix       = $urandom_range(MIX_FILL, MIX_ANY);
            phase_len = $urandom_range(20, 80);
         end
         k = 0;
         while (k < phase_len) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
               op = pick_opcode(mix);
               send_item(op, pick_value(op == OP_DELETE ? 85 : 70));
               k++;
               sent++;
            end
            gap = (phase == 2 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_chan.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         phase++;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d directed and %0d random requests in %0d phases, one long result hold-off.",
               21, sent, phase);
      $display("Statuses: %0d ok (%0d delete hits), %0d empty pops, %0d full pushes, %0d delete misses.",
               ok_count, delete_hits, empty_count, full_count, nomatch_count);
      if (fail_count == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
